[hdl/assert_macros.svh]
// Assertion macros for the RTL of the decimal square root unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define DSR_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define DSR_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define DSR_ASSERT_CLK(label, clk, rst_n, prop, msg)

`define DSR_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

[hdl/dsr_pkg.sv]
// Shared constants, types and helper functions of the decimal square root unit.
`default_nettype none

package dsr_pkg;

  localparam int RADICAND_BITS = 31;
  localparam int MAX_PLACES    = 4;
  localparam int PLACES_W      = 3;
  localparam int SCALE_W       = 14;
  localparam int SCALE_SQ_BITS = 27;
  localparam int PROD_W        = RADICAND_BITS + SCALE_SQ_BITS;
  localparam int ROOT_W        = (PROD_W + 1) / 2;
  localparam int REM_W         = ROOT_W + 1;
  localparam int ITER_W        = $clog2(ROOT_W);
  localparam int INT_W         = 16;
  localparam int FRAC_W        = 14;
  localparam int DATA_W        = 32;
  localparam int ADDR_W        = 3;
  localparam int FRAC_LIMIT    = 10000;

  typedef struct packed {
    logic              idle;
    logic              done;
    logic [INT_W-1:0]  integer_part;
    logic [FRAC_W-1:0] fraction_digits;
  } core_status_t;

  function automatic logic [PLACES_W-1:0] sat_places(input logic [PLACES_W-1:0] places);
    logic [PLACES_W-1:0] res;
    if (places > PLACES_W'(MAX_PLACES)) begin
      res = PLACES_W'(MAX_PLACES);
    end else begin
      res = places;
    end
    return res;
  endfunction

  function automatic logic [SCALE_W-1:0] scale_of(input logic [PLACES_W-1:0] places);
    logic [SCALE_W-1:0] res;
    case (places)
      3'd0:    res = SCALE_W'(1);
      3'd1:    res = SCALE_W'(10);
      3'd2:    res = SCALE_W'(100);
      3'd3:    res = SCALE_W'(1000);
      default: res = SCALE_W'(10000);
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

[hdl/dsr_core.sv]
// Sequential datapath: decimal scaling, radix-4 digit-recurrence root and bit-serial division.
`default_nettype none

module dsr_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [dsr_pkg::RADICAND_BITS-1:0] radicand_i,
  input  wire logic [dsr_pkg::PLACES_W-1:0]      places_i,
  input  wire logic                             ack_i,
  output dsr_pkg::core_status_t                 status_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCALE = 5'b00010,
    ST_ROOT  = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e                            state_q, state_d;
  logic [dsr_pkg::ITER_W-1:0]        cnt_q, cnt_d;
  logic [dsr_pkg::PROD_W-1:0]        val_q, val_d;
  logic [dsr_pkg::ROOT_W-1:0]        root_q, root_d;
  logic [dsr_pkg::REM_W-1:0]         rem_q, rem_d;
  logic [dsr_pkg::SCALE_W-1:0]       scale_q, scale_d;
  logic [dsr_pkg::PLACES_W-1:0]      places_sat;

  logic [dsr_pkg::REM_W+1:0]         root_rem;
  logic [dsr_pkg::REM_W+1:0]         root_trial;
  logic                              root_ge;
  logic [dsr_pkg::SCALE_W:0]         div_rem;
  logic                              div_ge;

  assign places_sat = dsr_pkg::sat_places(places_i);

  assign root_rem   = {rem_q, val_q[dsr_pkg::PROD_W-1 -: 2]};
  assign root_trial = (dsr_pkg::REM_W+2)'({root_q, 2'b01});
  assign root_ge    = (root_rem >= root_trial);

  assign div_rem = {rem_q[dsr_pkg::SCALE_W-1:0], root_q[dsr_pkg::ROOT_W-1]};
  assign div_ge  = (div_rem >= {1'b0, scale_q});

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    val_d   = val_q;
    root_d  = root_q;
    rem_d   = rem_q;
    scale_d = scale_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          val_d   = dsr_pkg::PROD_W'(radicand_i);
          cnt_d   = dsr_pkg::ITER_W'({places_sat, 1'b0});
          scale_d = dsr_pkg::scale_of(places_sat);
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (cnt_q == '0) begin
          cnt_d   = dsr_pkg::ITER_W'(dsr_pkg::ROOT_W - 1);
          root_d  = '0;
          rem_d   = '0;
          state_d = ST_ROOT;
        end else begin
          val_d = (val_q << 3) + (val_q << 1);
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_ROOT: begin
        val_d  = val_q << 2;
        root_d = {root_q[dsr_pkg::ROOT_W-2:0], root_ge};
        if (root_ge) begin
          rem_d = dsr_pkg::REM_W'(root_rem - root_trial);
        end else begin
          rem_d = dsr_pkg::REM_W'(root_rem);
        end
        if (cnt_q == '0) begin
          rem_d   = '0;
          cnt_d   = dsr_pkg::ITER_W'(dsr_pkg::ROOT_W - 1);
          state_d = ST_DIV;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_DIV: begin
        root_d = {root_q[dsr_pkg::ROOT_W-2:0], div_ge};
        if (div_ge) begin
          rem_d = dsr_pkg::REM_W'(dsr_pkg::SCALE_W'(div_rem - {1'b0, scale_q}));
        end else begin
          rem_d = dsr_pkg::REM_W'(dsr_pkg::SCALE_W'(div_rem));
        end
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_DONE: begin
        if (ack_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    root_q  <= root_d;
    rem_q   <= rem_d;
    scale_q <= scale_d;
  end

  assign status_o.idle            = (state_q == ST_IDLE);
  assign status_o.done            = (state_q == ST_DONE);
  assign status_o.integer_part    = root_q[dsr_pkg::INT_W-1:0];
  assign status_o.fraction_digits = rem_q[dsr_pkg::FRAC_W-1:0];

endmodule

`default_nettype wire

[hdl/decimal_square_root_unit.sv]
// Decimal square root unit: the top level with stream ports, register port and output register.
//
// Each radicand yields floor(sqrt(radicand * 100^p)) split into an integer part and p
// fraction digits, p being the decimal_places register (values above 4 act as 4).
// One transaction is in work at a time. It scales the radicand by 100^p in multiply-by-ten
// steps, runs the radix-4 root recurrence (two radicand bits per cycle), divides bit-serially
// by 10^p and hands the result over to the output register. The next radicand is taken once
// the core is idle again after the hand-over; a result held back by m_axis_tready stalls the
// core and the input with it.
// Write decimal_places only while the unit is idle.
`default_nettype none

module decimal_square_root_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // register port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [dsr_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [dsr_pkg::DATA_W-1:0]   pwdata,
  output      logic [dsr_pkg::DATA_W-1:0]   prdata,
  output      logic                         pready,
  // input stream
  input  wire logic                         s_axis_tvalid,
  output      logic                         s_axis_tready,
  input  wire logic [31:0]                  s_axis_tdata,  // [30:0] radicand, [31] zero
  // output stream
  output      logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output      logic [31:0]                  m_axis_tdata   // [15:0] integer_part,
                                                           // [29:16] fraction_digits, [31:30] zero
);

  `include "assert_macros.svh"

  logic [dsr_pkg::PLACES_W-1:0] places_q, places_d;
  logic                         m_valid_q, m_valid_d;
  logic [31:0]                  m_data_q;
  logic                         cfg_wr;
  logic                         start;
  logic                         load;
  dsr_pkg::core_status_t        core_status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];

  always_comb begin
    places_d = places_q;
    if (cfg_wr) begin
      places_d = pwdata[dsr_pkg::PLACES_W-1:0];
    end
  end

  assign prdata = paddr[2] ? '0 : dsr_pkg::DATA_W'(places_q);

  assign s_axis_tready = core_status.idle;
  assign start         = s_axis_tvalid && s_axis_tready;

  dsr_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .radicand_i (s_axis_tdata[dsr_pkg::RADICAND_BITS-1:0]),
    .places_i   (places_q),
    .ack_i      (load),
    .status_o   (core_status)
  );

  assign load = core_status.done && (!m_valid_q || m_axis_tready);

  always_comb begin
    m_valid_d = m_valid_q;
    if (load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      places_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      places_q  <= places_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      m_data_q <= {2'b00, core_status.fraction_digits, core_status.integer_part};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `DSR_ASSERT_CLK(a_busy_after_accept, clk_i, rst_ni, start |=> !s_axis_tready, "input taken while busy")
  `DSR_ASSERT_CLK(a_result_held, clk_i, rst_ni, core_status.done && m_valid_q && !m_axis_tready |=> core_status.done, "finished result dropped")
  `DSR_ASSERT_NEVER(a_frac_range, clk_i, rst_ni, m_valid_q && (m_data_q[29:16] >= 14'(dsr_pkg::FRAC_LIMIT)), "fraction out of range")

endmodule

`default_nettype wire
